// ===== rtl/core/qmn_pkg.sv =====
package qmn_pkg;

   // data widths
   localparam int DW    = 32;            // Q4.28 word
   localparam int FRAC  = 28;            // fraction bits
   localparam int HALF  = 1 << (FRAC - 1);
   localparam int OPW   = DW + 1;        // product operand, holds a negated word
   localparam int PW    = 64;            // product as held
   localparam int RW    = 36;            // rounded product
   localparam int QW    = 38;            // sum of four rounded products
   localparam int WIN   = 30;            // leading one of the largest magnitude lands here
   localparam int MW    = WIN + 1;       // aligned magnitude
   localparam int SW    = 2 * MW + 2;    // sum of four squares
   localparam int RTW   = DW;            // integer root
   localparam int QBITS = FRAC + 1;      // quotient bits, quotient stays below 2^29
   localparam int NUMW  = MW + FRAC + 1; // dividend

   // operation codes
   localparam logic OP_PRODUCT = 1'b0;
   localparam logic OP_ROTATE  = 1'b1;

   typedef logic [3:0][DW-1:0]  quat_type;
   typedef logic [3:0][QW-1:0]  wquat_type;
   typedef logic [3:0][OPW-1:0] opq_type;

   typedef struct packed {
      logic     op;
      quat_type a;
      logic     deg;
   } side_type;

   typedef struct packed {
      logic valid;
      logic skip;
   } ctl_type;

   typedef struct packed {
      logic               op;
      logic signed [31:0] a_w;
      logic signed [31:0] a_x;
      logic signed [31:0] a_y;
      logic signed [31:0] a_z;
      logic signed [31:0] b_w;
      logic signed [31:0] b_x;
      logic signed [31:0] b_y;
      logic signed [31:0] b_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] r_w;
      logic signed [31:0] r_x;
      logic signed [31:0] r_y;
      logic signed [31:0] r_z;
      logic               degenerate;
   } rsp_type;

endpackage

// ===== rtl/core/qmn_norm.sv =====
module qmn_norm (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  qmn_pkg::ctl_type   in_ctl,
   input  qmn_pkg::wquat_type in_vec,
   input  qmn_pkg::side_type  in_side,
   output logic               out_valid,
   output qmn_pkg::quat_type  out_vec,
   output qmn_pkg::side_type  out_side
);

   localparam int QW    = qmn_pkg::QW;
   localparam int MW    = qmn_pkg::MW;
   localparam int SW    = qmn_pkg::SW;
   localparam int DW    = qmn_pkg::DW;
   localparam int FRAC  = qmn_pkg::FRAC;
   localparam int NUMW  = qmn_pkg::NUMW;
   localparam int RTW   = qmn_pkg::RTW;
   localparam int QBITS = qmn_pkg::QBITS;
   localparam int PSW   = $clog2(QW);
   localparam int SQ_ST = SW / 4;        // two root bits per stage
   localparam logic [PSW-1:0] WIN_P = PSW'(qmn_pkg::WIN);

   typedef struct packed {
      logic               skip;
      logic               zero;
      logic [3:0]         neg;
      qmn_pkg::quat_type  raw;
      qmn_pkg::side_type  side;
   } carry_type;

   typedef logic [3:0][MW-1:0]     mag_type;
   typedef logic [3:0][2*MW-1:0]   sq_type;
   typedef logic [3:0][NUMW-1:0]   rem_type;
   typedef logic [3:0][QBITS-1:0]  quo_type;

   typedef struct packed {
      logic [SW-1:0] s;
      logic [SW-1:0] r;
   } sr_type;

   // one step of the bit-by-bit integer root
   function automatic sr_type sqrt_step(sr_type x, logic [SW-1:0] bitv);
      sr_type y;
      y = x;
      if (x.s >= x.r + bitv) begin
         y.s = x.s - (x.r + bitv);
         y.r = (x.r >> 1) + bitv;
      end else begin
         y.r = x.r >> 1;
      end
      return y;
   endfunction

   // stage A: sign and magnitude
   logic               va_ff;
   carry_type          ca_ff, ca_in;
   qmn_pkg::wquat_type maga_ff, maga_in;
   logic [QW-1:0]      orva_ff, orva_in;

   always_comb begin
      ca_in      = '0;
      ca_in.skip = in_ctl.skip;
      ca_in.side = in_side;
      orva_in    = '0;
      for (int i = 0; i < 4; i++) begin
         ca_in.neg[i] = in_vec[i][QW-1];
         ca_in.raw[i] = in_vec[i][DW-1:0];
         maga_in[i]   = in_vec[i][QW-1] ? (~in_vec[i] + QW'(1)) : in_vec[i];
         orva_in      = orva_in | maga_in[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) va_ff <= 1'b0;
      else if (adv) va_ff <= in_ctl.valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ca_ff   <= ca_in;
         maga_ff <= maga_in;
         orva_ff <= orva_in;
      end
   end

   // stage B: leading one position of the largest magnitude
   logic               vb_ff;
   carry_type          cb_ff, cb_in;
   qmn_pkg::wquat_type magb_ff;
   logic [PSW-1:0]     posb_ff, posb_in;

   always_comb begin
      posb_in = '0;
      for (int b = 0; b < QW; b++) begin
         if (orva_ff[b]) posb_in = PSW'(b);
      end
      cb_in      = ca_ff;
      cb_in.zero = (orva_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) vb_ff <= 1'b0;
      else if (adv) vb_ff <= va_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cb_ff   <= cb_in;
         magb_ff <= maga_ff;
         posb_ff <= posb_in;
      end
   end

   // stage C: common shift into the window
   logic      vc_ff;
   carry_type cc_ff;
   mag_type   mc_ff, mc_in;

   always_comb begin
      logic [QW-1:0] t;
      for (int i = 0; i < 4; i++) begin
         if (posb_ff > WIN_P) t = magb_ff[i] >> (posb_ff - WIN_P);
         else t = magb_ff[i] << (WIN_P - posb_ff);
         mc_in[i] = t[MW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) vc_ff <= 1'b0;
      else if (adv) vc_ff <= vb_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cc_ff <= cb_ff;
         mc_ff <= mc_in;
      end
   end

   // stage D: squares
   logic      vd_ff;
   carry_type cd_ff;
   mag_type   md_ff;
   sq_type    sqd_ff, sqd_in;

   always_comb begin
      for (int i = 0; i < 4; i++) sqd_in[i] = mc_ff[i] * mc_ff[i];
   end

   always_ff @(posedge clock) begin
      if (reset) vd_ff <= 1'b0;
      else if (adv) vd_ff <= vc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cd_ff  <= cc_ff;
         md_ff  <= mc_ff;
         sqd_ff <= sqd_in;
      end
   end

   // stage E and root pipeline; index 0 holds the sum of squares
   logic      sq_v_ff [SQ_ST+1];
   carry_type sq_c_ff [SQ_ST+1];
   mag_type   sq_m_ff [SQ_ST+1];
   sr_type    sq_x_ff [SQ_ST+1];
   sr_type    sum_in;

   always_comb begin
      sum_in.s = SW'(sqd_ff[0]) + SW'(sqd_ff[1]) + SW'(sqd_ff[2]) + SW'(sqd_ff[3]);
      sum_in.r = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else if (adv) sq_v_ff[0] <= vd_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_c_ff[0] <= cd_ff;
         sq_m_ff[0] <= md_ff;
         sq_x_ff[0] <= sum_in;
      end
   end

   for (genvar k = 0; k < SQ_ST; k++) begin : g_sqrt
      localparam logic [SW-1:0] BIT_HI = SW'(1) << (SW - 2 - 4 * k);
      localparam logic [SW-1:0] BIT_LO = SW'(1) << (SW - 4 - 4 * k);
      sr_type x_in;

      always_comb x_in = sqrt_step(sqrt_step(sq_x_ff[k], BIT_HI), BIT_LO);

      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[k+1] <= 1'b0;
         else if (adv) sq_v_ff[k+1] <= sq_v_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_c_ff[k+1] <= sq_c_ff[k];
            sq_m_ff[k+1] <= sq_m_ff[k];
            sq_x_ff[k+1] <= x_in;
         end
      end
   end

   // divider setup and restoring divide, one quotient bit per stage
   logic             dv_ff  [QBITS+1];
   carry_type        dc_ff  [QBITS+1];
   logic [RTW-1:0]   dm_ff  [QBITS+1];
   rem_type          drem_ff[QBITS+1];
   quo_type          dq_ff  [QBITS+1];
   logic [RTW-1:0]   root_in;
   rem_type          num_in;

   always_comb begin
      root_in = sq_x_ff[SQ_ST].r[RTW-1:0];
      for (int i = 0; i < 4; i++) begin
         num_in[i] = (NUMW'(sq_m_ff[SQ_ST][i]) << FRAC) + NUMW'(root_in >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else if (adv) dv_ff[0] <= sq_v_ff[SQ_ST];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dc_ff[0]   <= sq_c_ff[SQ_ST];
         dm_ff[0]   <= root_in;
         drem_ff[0] <= num_in;
         dq_ff[0]   <= '0;
      end
   end

   for (genvar k = 0; k < QBITS; k++) begin : g_div
      localparam int P = QBITS - 1 - k;
      rem_type rem_in;
      quo_type q_in;
      logic [NUMW-1:0] trial;

      always_comb begin
         trial  = NUMW'(dm_ff[k]) << P;
         rem_in = drem_ff[k];
         q_in   = dq_ff[k];
         for (int i = 0; i < 4; i++) begin
            if (drem_ff[k][i] >= trial) begin
               rem_in[i] = drem_ff[k][i] - trial;
               q_in[i][P] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) dv_ff[k+1] <= 1'b0;
         else if (adv) dv_ff[k+1] <= dv_ff[k];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dc_ff[k+1]   <= dc_ff[k];
            dm_ff[k+1]   <= dm_ff[k];
            drem_ff[k+1] <= rem_in;
            dq_ff[k+1]   <= q_in;
         end
      end
   end

   // output: restore signs; bypass and zero magnitude pass the input on
   logic              vo_ff;
   qmn_pkg::quat_type vec_ff, vec_in;
   qmn_pkg::side_type side_ff, side_in;

   always_comb begin
      carry_type c;
      c       = dc_ff[QBITS];
      side_in = c.side;
      for (int i = 0; i < 4; i++) begin
         if (c.skip || c.zero) vec_in[i] = c.raw[i];
         else if (c.neg[i]) vec_in[i] = ~DW'(dq_ff[QBITS][i]) + DW'(1);
         else vec_in[i] = DW'(dq_ff[QBITS][i]);
      end
      if (!c.skip && c.zero) side_in.deg = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) vo_ff <= 1'b0;
      else if (adv) vo_ff <= dv_ff[QBITS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         vec_ff  <= vec_in;
         side_ff <= side_in;
      end
   end

   assign out_valid = vo_ff;
   assign out_vec   = vec_ff;
   assign out_side  = side_ff;

endmodule

// ===== rtl/core/quaternion_multiply_normalize.sv =====
// An accepted request passes three normalizers of 52 stages each, set by the
// 16-stage root and 29-stage divider, plus two 3-stage Hamilton product units,
// on the way to its response. Throughput: one transaction per cycle while the response is not stalled.
// A stalled response freezes the whole pipeline; bubbles are not squeezed out.
// Reset (synchronous) clears all valid bits; data registers are not reset.
module quaternion_multiply_normalize (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  qmn_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output qmn_pkg::rsp_type rsp_data
);

   localparam int OPW  = qmn_pkg::OPW;
   localparam int PW   = qmn_pkg::PW;
   localparam int RW   = qmn_pkg::RW;
   localparam int QW   = qmn_pkg::QW;
   localparam int FRAC = qmn_pkg::FRAC;

   typedef struct packed {
      logic              skip;
      qmn_pkg::quat_type raw;
      qmn_pkg::side_type side;
   } hcarry_type;

   logic adv;

   // whole pipeline moves unless a held response is stalled
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   // first normalizer: vector to rotate, bypassed in product mode
   qmn_pkg::ctl_type   na_ctl;
   qmn_pkg::wquat_type na_in;
   qmn_pkg::side_type  na_side_in;
   logic               na_valid;
   qmn_pkg::quat_type  na_vec;
   qmn_pkg::side_type  na_side;

   always_comb begin
      na_ctl.valid  = req_valid;
      na_ctl.skip   = (req_data.op == qmn_pkg::OP_PRODUCT);
      na_in[0]      = na_ctl.skip ? QW'(req_data.b_w) : '0;
      na_in[1]      = QW'(req_data.b_x);
      na_in[2]      = QW'(req_data.b_y);
      na_in[3]      = QW'(req_data.b_z);
      na_side_in.op = req_data.op;
      na_side_in.a  = {req_data.a_z, req_data.a_y, req_data.a_x, req_data.a_w};
      na_side_in.deg = 1'b0;
   end

   qmn_norm u_norm_a (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (na_ctl),
      .in_vec   (na_in),
      .in_side  (na_side_in),
      .out_valid(na_valid),
      .out_vec  (na_vec),
      .out_side (na_side)
   );

   // Hamilton product units: 0 is a*b, 1 is p*conj(a) (bypassed in product mode)
   logic               h_valid [2];
   logic               h_skip  [2];
   qmn_pkg::opq_type   h_left  [2];
   qmn_pkg::opq_type   h_right [2];
   qmn_pkg::quat_type  h_raw   [2];
   qmn_pkg::side_type  h_side  [2];
   logic               ho_valid[2];
   qmn_pkg::wquat_type ho_vec  [2];
   qmn_pkg::side_type  ho_side [2];

   qmn_pkg::ctl_type   nb_ctl;
   logic               nb_valid;
   qmn_pkg::quat_type  nb_vec;
   qmn_pkg::side_type  nb_side;

   always_comb begin
      h_valid[0] = na_valid;
      h_skip[0]  = 1'b0;
      h_raw[0]   = na_vec;
      h_side[0]  = na_side;
      for (int i = 0; i < 4; i++) begin
         h_left[0][i]  = OPW'($signed(na_side.a[i]));
         h_right[0][i] = OPW'($signed(na_vec[i]));
      end

      h_valid[1] = nb_valid;
      h_skip[1]  = (nb_side.op == qmn_pkg::OP_PRODUCT);
      h_raw[1]   = nb_vec;
      h_side[1]  = nb_side;
      for (int i = 0; i < 4; i++) begin
         h_left[1][i] = OPW'($signed(nb_vec[i]));
      end
      h_right[1][0] = OPW'($signed(nb_side.a[0]));
      for (int i = 1; i < 4; i++) begin
         h_right[1][i] = -OPW'($signed(nb_side.a[i]));
      end
   end

   for (genvar g = 0; g < 2; g++) begin : g_ham
      logic                   v1_ff, v2_ff, v3_ff;
      hcarry_type             c1_ff, c2_ff, c1_in;
      logic signed [2*OPW-1:0] full_in [4][4];
      logic signed [PW-1:0]   prod_ff [4][4];
      logic signed [RW-1:0]   rnd_ff  [4][4];
      logic signed [RW-1:0]   rnd_in  [4][4];
      qmn_pkg::wquat_type     sum_ff, sum_in;
      qmn_pkg::side_type      side3_ff;

      // stage 1: sixteen products
      always_comb begin
         c1_in.skip = h_skip[g];
         c1_in.raw  = h_raw[g];
         c1_in.side = h_side[g];
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               full_in[i][j] = $signed(h_left[g][i]) * $signed(h_right[g][j]);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            c1_ff <= c1_in;
            for (int i = 0; i < 4; i++) begin
               for (int j = 0; j < 4; j++) prod_ff[i][j] <= full_in[i][j][PW-1:0];
            end
         end
      end

      // stage 2: round half up to Q.28
      always_comb begin
         logic signed [PW-1:0] t;
         for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
               t = (prod_ff[i][j] + PW'(qmn_pkg::HALF)) >>> FRAC;
               rnd_in[i][j] = t[RW-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            c2_ff  <= c1_ff;
            rnd_ff <= rnd_in;
         end
      end

      // stage 3: combine terms
      always_comb begin
         if (c2_ff.skip) begin
            for (int i = 0; i < 4; i++) sum_in[i] = QW'($signed(c2_ff.raw[i]));
         end else begin
            sum_in[0] = QW'(rnd_ff[0][0]) - QW'(rnd_ff[1][1])
                      - QW'(rnd_ff[2][2]) - QW'(rnd_ff[3][3]);
            sum_in[1] = QW'(rnd_ff[2][3]) - QW'(rnd_ff[3][2])
                      + QW'(rnd_ff[1][0]) + QW'(rnd_ff[0][1]);
            sum_in[2] = QW'(rnd_ff[3][1]) - QW'(rnd_ff[1][3])
                      + QW'(rnd_ff[2][0]) + QW'(rnd_ff[0][2]);
            sum_in[3] = QW'(rnd_ff[1][2]) - QW'(rnd_ff[2][1])
                      + QW'(rnd_ff[3][0]) + QW'(rnd_ff[0][3]);
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sum_ff   <= sum_in;
            side3_ff <= c2_ff.side;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v1_ff <= 1'b0;
            v2_ff <= 1'b0;
            v3_ff <= 1'b0;
         end else if (adv) begin
            v1_ff <= h_valid[g];
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
         end
      end

      assign ho_valid[g] = v3_ff;
      assign ho_vec[g]   = sum_ff;
      assign ho_side[g]  = side3_ff;
   end

   // second normalizer: always active
   assign nb_ctl.valid = ho_valid[0];
   assign nb_ctl.skip  = 1'b0;

   qmn_norm u_norm_b (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (nb_ctl),
      .in_vec   (ho_vec[0]),
      .in_side  (ho_side[0]),
      .out_valid(nb_valid),
      .out_vec  (nb_vec),
      .out_side (nb_side)
   );

   // third normalizer: rotate mode only; its output register is the response
   qmn_pkg::ctl_type  nc_ctl;
   qmn_pkg::quat_type nc_vec;
   qmn_pkg::side_type nc_side;

   assign nc_ctl.valid = ho_valid[1];
   assign nc_ctl.skip  = (ho_side[1].op == qmn_pkg::OP_PRODUCT);

   qmn_norm u_norm_c (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_ctl   (nc_ctl),
      .in_vec   (ho_vec[1]),
      .in_side  (ho_side[1]),
      .out_valid(rsp_valid),
      .out_vec  (nc_vec),
      .out_side (nc_side)
   );

   always_comb begin
      rsp_data.r_w = (nc_side.op == qmn_pkg::OP_ROTATE) ? '0 : $signed(nc_vec[0]);
      rsp_data.r_x = $signed(nc_vec[1]);
      rsp_data.r_y = $signed(nc_vec[2]);
      rsp_data.r_z = $signed(nc_vec[3]);
      rsp_data.degenerate = nc_side.deg;
   end

   // a zero magnitude anywhere forces every later stage to zero
   a_deg_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |->
         rsp_data.r_w == '0 && rsp_data.r_x == '0 &&
         rsp_data.r_y == '0 && rsp_data.r_z == '0)
      else $error("degenerate response with nonzero components");

   // normalized x, y and z components never exceed one in magnitude
   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         $signed(rsp_data.r_x) <= $signed(32'sh1000_0000) &&
         $signed(rsp_data.r_x) >= $signed(-32'sh1000_0000) &&
         $signed(rsp_data.r_y) <= $signed(32'sh1000_0000) &&
         $signed(rsp_data.r_y) >= $signed(-32'sh1000_0000) &&
         $signed(rsp_data.r_z) <= $signed(32'sh1000_0000) &&
         $signed(rsp_data.r_z) >= $signed(-32'sh1000_0000))
      else $error("normalized component out of range");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

// ===== tb/sv/quaternion_multiply_normalize_test.sv =====
module quaternion_multiply_normalize_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY     = 162;
   localparam int IDLE_LIMIT  = 20000;
   localparam int RANDOM_ITEMS = 550;
   localparam logic [31:0] ONE_Q   = 32'h1000_0000;
   localparam logic [31:0] MAX_Q   = 32'h7FFF_FFFF;
   localparam logic [31:0] MIN_Q   = 32'h8000_0000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   qmn_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   qmn_pkg::rsp_type rsp_data;

   quaternion_multiply_normalize dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   typedef longint signed comp4_type[4];

   qmn_pkg::rsp_type expected_results[$];
   int               error_count;
   int               idle_cycles;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Q.28 product, rounded half up
   function automatic longint signed qprod(longint signed x, longint signed y);
      longint signed p;
      p = x * y + 64'sd134217728;
      return p >>> 28;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned s);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic void hamilton_prod(input comp4_type a, input comp4_type b,
                                         output comp4_type o);
      o[0] = qprod(a[0], b[0]) - qprod(a[1], b[1]) - qprod(a[2], b[2]) - qprod(a[3], b[3]);
      o[1] = qprod(a[2], b[3]) - qprod(a[3], b[2]) + qprod(a[1], b[0]) + qprod(b[1], a[0]);
      o[2] = qprod(a[3], b[1]) - qprod(a[1], b[3]) + qprod(a[2], b[0]) + qprod(b[2], a[0]);
      o[3] = qprod(a[1], b[2]) - qprod(a[2], b[1]) + qprod(a[3], b[0]) + qprod(b[3], a[0]);
   endfunction

   // scale to unit length; returns 1 on zero magnitude
   function automatic bit unit_scale(inout comp4_type c);
      longint unsigned mag[4];
      longint unsigned mx, s, m, q;
      bit neg[4];
      mx = 0;
      s = 0;
      for (int i = 0; i < 4; i++) begin
         neg[i] = c[i] < 0;
         mag[i] = neg[i] ? longint'(-c[i]) : longint'(c[i]);
         if (mag[i] > mx) mx = mag[i];
      end
      if (mx == 0) return 1'b1;
      while (mx >= (64'd1 << 31)) begin
         mx = mx >> 1;
         for (int i = 0; i < 4; i++) mag[i] = mag[i] >> 1;
      end
      while (mx < (64'd1 << 30)) begin
         mx = mx << 1;
         for (int i = 0; i < 4; i++) mag[i] = mag[i] << 1;
      end
      for (int i = 0; i < 4; i++) s += mag[i] * mag[i];
      m = int_sqrt(s);
      for (int i = 0; i < 4; i++) begin
         q = ((mag[i] << 28) + (m >> 1)) / m;
         if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
         c[i] = neg[i] ? -longint'(q) : longint'(q);
      end
      return 1'b0;
   endfunction

   function automatic qmn_pkg::rsp_type predict_unit_quat(qmn_pkg::req_type t);
      comp4_type a, b, p, ac, r;
      bit deg;
      qmn_pkg::rsp_type res;
      a = '{longint'(t.a_w), longint'(t.a_x), longint'(t.a_y), longint'(t.a_z)};
      b = '{longint'(t.b_w), longint'(t.b_x), longint'(t.b_y), longint'(t.b_z)};
      if (t.op == qmn_pkg::OP_PRODUCT) begin
         hamilton_prod(a, b, r);
         deg = unit_scale(r);
      end else begin
         b[0] = 0;
         deg = unit_scale(b);
         hamilton_prod(a, b, p);
         if (unit_scale(p)) deg = 1'b1;
         ac[0] = a[0];
         for (int i = 1; i < 4; i++) ac[i] = -a[i];
         hamilton_prod(p, ac, r);
         if (unit_scale(r)) deg = 1'b1;
         r[0] = 0;
      end
      res.r_w = r[0][31:0];
      res.r_x = r[1][31:0];
      res.r_y = r[2][31:0];
      res.r_z = r[3][31:0];
      res.degenerate = deg;
      return res;
   endfunction

   // directed rows: stimulus, optional typed expectation
   typedef struct {
      qmn_pkg::req_type t;
      bit               has_exp;
      qmn_pkg::rsp_type e;
   } row_type;

   function automatic qmn_pkg::req_type mk(logic op, logic [31:0] aw, logic [31:0] ax,
                                           logic [31:0] ay, logic [31:0] az,
                                           logic [31:0] bw, logic [31:0] bx,
                                           logic [31:0] by, logic [31:0] bz);
      qmn_pkg::req_type t;
      t = '{op, aw, ax, ay, az, bw, bx, by, bz};
      return t;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return MAX_Q;
         1: return MIN_Q;
         2: return 32'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
         3: return 32'(int'($urandom_range(0, 64)) - 32);
         4: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // valid stays high from one transaction into the next when no idle is drawn
   task automatic send(qmn_pkg::req_type t);
      int waits;
      waits = $urandom_range(0, 12);
      if (waits != 0) begin
         req_valid <= 1'b0;
         repeat (waits) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // accepted request: queue its prediction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         expected_results.push_back(predict_unit_quat(req_data));
      end
   end

   // directed expectations pushed in place of predictions
   qmn_pkg::rsp_type typed_exp[$];
   bit               typed_flag[$];

   // response check
   always @(posedge clock) begin
      qmn_pkg::rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("response with nothing expected: %h", rsp_data);
            error_count++;
         end else begin
            e = expected_results.pop_front();
            if (typed_flag.size() != 0) begin
               if (typed_flag.pop_front()) begin
                  e = typed_exp.pop_front();
               end
            end
            if (rsp_data.r_w !== e.r_w) begin
               $error("r_w expected %h actual %h", e.r_w, rsp_data.r_w);
               error_count++;
            end
            if (rsp_data.r_x !== e.r_x) begin
               $error("r_x expected %h actual %h", e.r_x, rsp_data.r_x);
               error_count++;
            end
            if (rsp_data.r_y !== e.r_y) begin
               $error("r_y expected %h actual %h", e.r_y, rsp_data.r_y);
               error_count++;
            end
            if (rsp_data.r_z !== e.r_z) begin
               $error("r_z expected %h actual %h", e.r_z, rsp_data.r_z);
               error_count++;
            end
            if (rsp_data.degenerate !== e.degenerate) begin
               $error("degenerate expected %b actual %b", e.degenerate, rsp_data.degenerate);
               error_count++;
            end
         end
      end
   end

   // response-side stall: random waits per transaction, with quiet stretches
   initial begin
      int waits;
      rsp_stall = 1'b1;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         if (waits != 0) begin
            rsp_stall <= 1'b1;
            repeat (waits) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // watchdog on transactions in either direction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      row_type rows[$];
      row_type rw;
      qmn_pkg::req_type t;
      qmn_pkg::rsp_type z;
      int n;
      error_count = 0;
      idle_cycles = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      z = '0;

      // zero magnitude and zero rotate vector: degenerate, all zero
      z.degenerate = 1'b1;
      rows.push_back('{mk(qmn_pkg::OP_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, z});
      rows.push_back('{mk(qmn_pkg::OP_ROTATE, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0), 1'b1, z});
      rows.push_back('{mk(qmn_pkg::OP_ROTATE, 0, 0, 0, 0, 0, ONE_Q, 0, 0), 1'b1, z});
      // identity times identity
      rw.t = mk(qmn_pkg::OP_PRODUCT, ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0);
      rw.has_exp = 1'b1;
      rw.e = '{ONE_Q, 32'd0, 32'd0, 32'd0, 1'b0};
      rows.push_back(rw);
      // extremes and mixed signs, checked by the predictor
      rows.push_back('{mk(qmn_pkg::OP_PRODUCT, MAX_Q, MAX_Q, MAX_Q, MAX_Q,
                          MAX_Q, MAX_Q, MAX_Q, MAX_Q), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_PRODUCT, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                          MIN_Q, MIN_Q, MIN_Q, MIN_Q), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_PRODUCT, MAX_Q, MIN_Q, MAX_Q, MIN_Q,
                          MIN_Q, MAX_Q, MIN_Q, MAX_Q), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_ROTATE, MAX_Q, MIN_Q, MAX_Q, MIN_Q,
                          MIN_Q, MAX_Q, MIN_Q, MAX_Q), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_ROTATE, MIN_Q, MIN_Q, MIN_Q, MIN_Q,
                          MAX_Q, MIN_Q, MIN_Q, MIN_Q), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_PRODUCT, 1, 0, 0, 0, 1, 0, 0, 0), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_PRODUCT, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 1,
                          1, 1, 1, 1), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_ROTATE, 0, ONE_Q, 0, 0, 0, 0, ONE_Q, 0), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_ROTATE, 1, 0, 0, 0, 0, 1, 0, 0), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_ROTATE, ONE_Q, ONE_Q, ONE_Q, ONE_Q,
                          0, 3, 32'hFFFF_FFFD, 7), 1'b0, z});
      rows.push_back('{mk(qmn_pkg::OP_PRODUCT, 32'h0800_0000, 32'hF800_0000, 32'h0400_0000, 0,
                          0, 32'h1000_0000, 32'hF000_0000, 32'h0123_4567), 1'b0, z});

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         typed_flag.push_back(rows[i].has_exp);
         if (rows[i].has_exp) typed_exp.push_back(rows[i].e);
         send(rows[i].t);
      end

      // random: each word is an extreme, a value in [-1, 1], a small value, zero or a raw word
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         t.op  = 1'($urandom_range(0, 1));
         t.a_w = rand_word();
         t.a_x = rand_word();
         t.a_y = rand_word();
         t.a_z = rand_word();
         t.b_w = rand_word();
         t.b_x = rand_word();
         t.b_y = rand_word();
         t.b_z = rand_word();
         send(t);
      end
      req_valid <= 1'b0;

      // drain, then let the pipeline settle
      n = 0;
      while (expected_results.size() != 0 && n < 100000) begin
         @(posedge clock);
         n++;
      end
      repeat (LATENCY + 20) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
